FILE: rtl/pef_pkg.sv
// Shared constants, types and command encoding for the postfix stack evaluator.
package pef_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 6;
    localparam int STACK_DEPTH = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUSH = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

endpackage

FILE: rtl/pef_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pef_ram #(
    parameter int WIDTH = pef_pkg::DATA_W,
    parameter int DEPTH = pef_pkg::STACK_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pef_fifo.sv
// Short command queue between the classifying front end and the stack engine.
module pef_fifo #(
    parameter int DEPTH = pef_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pef_pkg::cmd_t wdata,
    input  logic          pop,
    output pef_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pef_pkg::cmd_t  slots [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  fill_reg;
    logic [CW-1:0]  fill_next;

    assign full  = (fill_reg == CW'(DEPTH));
    assign empty = (fill_reg == '0);
    assign rdata = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/pef_front.sv
// Front end: takes character beats and turns them into stack commands.
module pef_front (
    input  logic          sym_valid,
    output logic          sym_stall,
    input  logic [7:0]    symbol,
    input  logic          last,
    input  logic          q_full,
    output logic          q_push,
    output pef_pkg::cmd_t q_cmd
);

    logic [7:0] digit_full;

    assign sym_stall  = q_full;
    assign q_push     = sym_valid && !q_full;
    assign digit_full = symbol - pef_pkg::CHAR_0;

    always_comb
    begin
        q_cmd.digit = digit_full[3:0];
        q_cmd.last  = last;
        case (symbol) inside
            [pef_pkg::CHAR_0:pef_pkg::CHAR_9]: q_cmd.op = pef_pkg::OP_PUSH;
            pef_pkg::CHAR_PLUS:                q_cmd.op = pef_pkg::OP_ADD;
            pef_pkg::CHAR_MINUS:               q_cmd.op = pef_pkg::OP_SUB;
            pef_pkg::CHAR_STAR:                q_cmd.op = pef_pkg::OP_MUL;
            pef_pkg::CHAR_SLASH:               q_cmd.op = pef_pkg::OP_DIV;
            default:                           q_cmd.op = pef_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: rtl/pef_div.sv
// Iterative radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
module pef_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pef_pkg::DATA_W-1:0]  dividend,
    input  logic [pef_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pef_pkg::DATA_W-1:0]  quotient
);

    localparam int DW = pef_pkg::DATA_W;
    localparam int SW = $clog2(DW);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] den_next;
    logic          neg_reg;
    logic          neg_next;
    logic [DW:0]   shifted;
    logic          fits;
    logic [DW:0]   diff;

    assign shifted  = {rem_reg, quo_reg[DW-1]};
    assign fits     = (shifted >= {1'b0, den_reg});
    assign diff     = shifted - {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (DW'(0) - quo_reg) : quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
            den_next  = divisor[DW-1] ? (DW'(0) - divisor) : divisor;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

endmodule

FILE: rtl/pef_back.sv
// Back end: executes queued commands on the operand stack and holds the result beat.
module pef_back #(
    parameter int STACK_DEPTH = pef_pkg::STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  pef_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [pef_pkg::DATA_W-1:0] top_value,
    output logic [pef_pkg::DEPTH_W-1:0]       depth,
    output logic [1:0]                        status,
    output logic                              done_res
);

    localparam int DW    = pef_pkg::DATA_W;
    localparam int DPW   = pef_pkg::DEPTH_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_OPER = 3'b010,
        S_DIV  = 3'b100
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DW-1:0]    top_reg;
    logic [DW-1:0]    top_next;
    pef_pkg::cmd_t    cmd_reg;
    pef_pkg::cmd_t    cmd_next;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic [DW-1:0]        top_value_reg;
    logic [CNT_W-1:0]     depth_reg;
    pef_pkg::status_t     status_reg;
    logic                 done_reg;

    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     cnt_m2;
    logic                 out_free;
    logic                 ram_we;
    logic [DW-1:0]        ram_rdata;
    logic [DW-1:0]        left_op;
    logic [DW-1:0]        mul_lo;
    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_quo;

    logic                 rep;
    logic [DW-1:0]        rep_top;
    logic [CNT_W-1:0]     rep_cnt;
    pef_pkg::status_t     rep_status;
    logic                 rep_last;
    logic                 fin;
    logic [DW-1:0]        fin_res;
    logic [CNT_W+DPW-1:0] depth_ext;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign out_free = !res_valid_reg || !res_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty && out_free;
    assign left_op  = ram_rdata;
    assign mul_lo   = left_op * top_reg;

    // Entries below the top live in RAM; the top of stack is kept in top_reg.
    pef_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_m1[AW-1:0]),
        .wdata (top_reg),
        .raddr (cnt_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    pef_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_op),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        cmd_next   = cmd_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        rep        = 1'b0;
        rep_top    = top_reg;
        rep_cnt    = cnt_reg;
        rep_status = pef_pkg::ST_OK;
        rep_last   = cmd_reg.last;
        fin        = 1'b0;
        fin_res    = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next = q_cmd;
                    rep_last = q_cmd.last;
                    case (q_cmd.op)
                        pef_pkg::OP_NOP:
                        begin
                            rep = 1'b1;
                        end
                        pef_pkg::OP_PUSH:
                        begin
                            rep = 1'b1;
                            if (cnt_reg == CNT_W'(STACK_DEPTH))
                            begin
                                rep_status = pef_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we   = (cnt_reg != '0);
                                top_next = DW'(q_cmd.digit);
                                cnt_next = cnt_reg + CNT_W'(1);
                                rep_top  = top_next;
                                rep_cnt  = cnt_next;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                rep        = 1'b1;
                                rep_status = pef_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = S_OPER;
                            end
                        end
                    endcase
                end
            end
            S_OPER:
            begin
                case (cmd_reg.op)
                    pef_pkg::OP_ADD:
                    begin
                        fin     = 1'b1;
                        fin_res = left_op + top_reg;
                    end
                    pef_pkg::OP_SUB:
                    begin
                        fin     = 1'b1;
                        fin_res = left_op - top_reg;
                    end
                    pef_pkg::OP_MUL:
                    begin
                        fin     = 1'b1;
                        fin_res = mul_lo;
                    end
                    pef_pkg::OP_DIV:
                    begin
                        if (top_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_res    = '0;
                            rep_status = pef_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fin     = 1'b1;
                    fin_res = div_quo;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Two operands collapse into one result that becomes the new top.
        if (fin)
        begin
            top_next   = fin_res;
            cnt_next   = cnt_m1;
            rep        = 1'b1;
            rep_top    = fin_res;
            rep_cnt    = cnt_m1;
            state_next = S_IDLE;
        end

        // The final character reports the stack first, then empties it.
        if (rep && rep_last)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (rep)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        cmd_reg <= cmd_next;
        if (rep)
        begin
            top_value_reg <= (rep_cnt == '0) ? '0 : rep_top;
            depth_reg     <= rep_cnt;
            status_reg    <= rep_status;
            done_reg      <= rep_last;
        end
    end

    assign depth_ext = {DPW'(0), depth_reg};
    assign res_valid = res_valid_reg;
    assign top_value = $signed(top_value_reg);
    assign depth     = depth_ext[DPW-1:0];
    assign status    = status_reg;
    assign done_res  = done_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_oper_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPER) |-> (cnt_reg >= CNT_W'(2)))
        else $error("operator executing with fewer than two entries");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished while not awaited");

    a_op_pops_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPER && cmd_reg.op != pef_pkg::OP_DIV && !cmd_reg.last)
        |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("binary operator did not reduce the stack by one");

endmodule

FILE: rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: character front end, command queue, stack engine.
//
// The input channel (sym_valid, sym_stall, symbol, last) carries one ASCII
// character per beat. Digits push their value, + - * / combine the two top
// entries, and all other characters are ignored. The output channel
// (res_valid, res_stall, top_value, depth, status, done_res) returns exactly
// one beat per input beat, in order, with the top of stack, the depth and a
// status code. A beat with last set reports and then empties the stack.
// Input beats go into a four-entry queue, so sym_stall rises only when that
// queue is full; the stack engine drains it one command at a time.
// The engine finishes a digit, an ignored character, an overflow or an
// underflow as it takes the command, passes + - * and a division by zero
// through its operate state, and sends any other / to the radix-2 divider,
// which produces one quotient bit per cycle. A result is registered and
// shows on the output in the cycle after the engine finishes the command.
// Reset clears the queue, the stack depth and the output valid at once; no
// clearing pass runs. While res_stall holds, the result beat waits in its
// register, the engine stops taking commands, and input beats keep landing in
// the queue until it fills.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pef_pkg::STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sym_valid,
    output logic                              sym_stall,
    input  logic [7:0]                        symbol,
    input  logic                              last,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [pef_pkg::DATA_W-1:0] top_value,
    output logic [pef_pkg::DEPTH_W-1:0]       depth,
    output logic [1:0]                        status,
    output logic                              done_res
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    pef_pkg::cmd_t q_wcmd;
    pef_pkg::cmd_t q_rcmd;

    pef_front u_front (
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .symbol    (symbol),
        .last      (last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_wcmd)
    );

    pef_fifo #(
        .DEPTH (pef_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wcmd),
        .pop   (q_pop),
        .rdata (q_rcmd),
        .full  (q_full),
        .empty (q_empty)
    );

    pef_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_rcmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .top_value (top_value),
        .depth     (depth),
        .status    (status),
        .done_res  (done_res)
    );

endmodule
